@@ hw/rtl/hniv_pkg.sv @@
// hniv_pkg: shared types and constants of the host name / ipv4 validator
// no dependencies; used by every module of the block
`default_nettype none

package hniv_pkg;

    // byte counter saturates here
    localparam int unsigned CHAR_COUNT_W    = 8;
    localparam logic [7:0]  CHAR_COUNT_MAX  = 8'd255;
    // dotted quad must be shorter than this
    localparam logic [7:0]  IPV4_TEXT_BYTES = 8'd16;
    localparam logic [6:0]  LABEL_MAX       = 7'd63;
    localparam logic [6:0]  LABEL_SAT       = 7'd64;
    localparam logic [47:0] LOCAL_SUFFIX    = 48'h2E6C6F63616C;  // ".local"
    localparam logic [7:0]  LOOPBACK_LEN    = 8'd9;               // "localhost"
    localparam logic [7:0]  SUFFIX_LEN      = 8'd6;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // end-of-text summary handed from the scanner to the verdict stage
    typedef struct packed {
        logic        quad_ok;
        logic [31:0] addr;
        logic        name_ok;
        logic        too_long;
    } verdict_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] loopback_char(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h6C;  // l
            4'd1:    r = 8'h6F;  // o
            4'd2:    r = 8'h63;  // c
            4'd3:    r = 8'h61;  // a
            4'd4:    r = 8'h6C;  // l
            4'd5:    r = 8'h68;  // h
            4'd6:    r = 8'h6F;  // o
            4'd7:    r = 8'h73;  // s
            4'd8:    r = 8'h74;  // t
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hniv_front.sv @@
// hniv_front: per-byte scanner for dotted quad and dns name rules
// depends on hniv_pkg; pushes one verdict_t per end marker
`default_nettype none

module hniv_front #(
    parameter int unsigned MAX_HOST_BYTES = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              beat_take,   // input beat accepted
    input  wire logic [7:0]        host_byte,
    input  wire logic              end_of_host,
    output logic                   push,
    output hniv_pkg::verdict_t     push_data
);

    logic [7:0]  char_count_reg,   char_count_next;
    logic [7:0]  octet_value_reg,  octet_value_next;
    logic [1:0]  octet_digits_reg, octet_digits_next;
    logic [1:0]  dots_seen_reg,    dots_seen_next;
    logic [23:0] addr_acc_reg,     addr_acc_next;
    logic        quad_failed_reg,  quad_failed_next;
    logic [6:0]  label_len_reg,    label_len_next;
    logic        name_failed_reg,  name_failed_next;
    logic [7:0]  prev_char_reg,    prev_char_next;
    logic [47:0] tail_reg,         tail_next;
    logic        loop_match_reg,   loop_match_next;

    logic [7:0]  lc;
    logic        is_digit;
    logic        is_alnum;
    logic [11:0] octet_sum;
    logic [6:0]  label_inc;
    logic        quad_ok;
    logic        name_ok;
    logic [7:0]  max_bytes;

    assign max_bytes = 8'(MAX_HOST_BYTES);
    assign lc        = hniv_pkg::fold_case(host_byte);
    assign is_digit  = host_byte >= 8'h30 && host_byte <= 8'h39;
    assign is_alnum  = is_digit || (lc >= 8'h61 && lc <= 8'h7A);
    assign octet_sum = 12'(octet_value_reg) * 12'd10 + {8'd0, host_byte[3:0]};
    assign label_inc = (label_len_reg < hniv_pkg::LABEL_SAT) ? label_len_reg + 7'd1
                                                              : label_len_reg;

    // end-of-text summary
    assign quad_ok = !quad_failed_reg && char_count_reg != 8'd0 &&
                     char_count_reg < hniv_pkg::IPV4_TEXT_BYTES &&
                     dots_seen_reg == 2'd3 && octet_digits_reg != 2'd0;
    assign name_ok = !name_failed_reg && char_count_reg != 8'd0 &&
                     char_count_reg <= max_bytes && label_len_reg != 7'd0 &&
                     prev_char_reg != hniv_pkg::CHAR_DASH &&
                     !(char_count_reg >= hniv_pkg::SUFFIX_LEN &&
                       tail_reg == hniv_pkg::LOCAL_SUFFIX) &&
                     !(char_count_reg == hniv_pkg::LOOPBACK_LEN && loop_match_reg);

    assign push               = beat_take && end_of_host;
    assign push_data.quad_ok  = quad_ok;
    assign push_data.addr     = quad_ok ? {addr_acc_reg, octet_value_reg} : 32'd0;
    assign push_data.name_ok  = name_ok;
    assign push_data.too_long = char_count_reg > max_bytes;

    always_comb begin
        char_count_next   = char_count_reg;
        octet_value_next  = octet_value_reg;
        octet_digits_next = octet_digits_reg;
        dots_seen_next    = dots_seen_reg;
        addr_acc_next     = addr_acc_reg;
        quad_failed_next  = quad_failed_reg;
        label_len_next    = label_len_reg;
        name_failed_next  = name_failed_reg;
        prev_char_next    = prev_char_reg;
        tail_next         = tail_reg;
        loop_match_next   = loop_match_reg;

        if (beat_take && end_of_host) begin
            // back to the start state for the next text
            char_count_next   = 8'd0;
            octet_value_next  = 8'd0;
            octet_digits_next = 2'd0;
            dots_seen_next    = 2'd0;
            addr_acc_next     = 24'd0;
            quad_failed_next  = 1'b0;
            label_len_next    = 7'd0;
            name_failed_next  = 1'b0;
            prev_char_next    = 8'd0;
            tail_next         = 48'd0;
            loop_match_next   = 1'b1;
        end else if (beat_take) begin
            // dotted quad
            if (quad_failed_reg || char_count_reg >= hniv_pkg::IPV4_TEXT_BYTES) begin
                quad_failed_next = 1'b1;
            end else if (is_digit) begin
                if (octet_digits_reg == 2'd3 || octet_sum > 12'd255) begin
                    quad_failed_next = 1'b1;
                end else begin
                    octet_value_next  = octet_sum[7:0];
                    octet_digits_next = octet_digits_reg + 2'd1;
                end
            end else if (host_byte == hniv_pkg::CHAR_DOT) begin
                if (octet_digits_reg == 2'd0 || dots_seen_reg == 2'd3) begin
                    quad_failed_next = 1'b1;
                end else begin
                    addr_acc_next     = {addr_acc_reg[15:0], octet_value_reg};
                    dots_seen_next    = dots_seen_reg + 2'd1;
                    octet_digits_next = 2'd0;
                    octet_value_next  = 8'd0;
                end
            end else begin
                quad_failed_next = 1'b1;
            end

            // dns name labels
            if (host_byte == hniv_pkg::CHAR_DOT) begin
                if (label_len_reg == 7'd0 || prev_char_reg == hniv_pkg::CHAR_DASH) begin
                    name_failed_next = 1'b1;
                end
                label_len_next = 7'd0;
            end else if (is_alnum || host_byte == hniv_pkg::CHAR_DASH) begin
                if (label_len_reg == 7'd0 && host_byte == hniv_pkg::CHAR_DASH) begin
                    name_failed_next = 1'b1;
                end
                if (label_inc > hniv_pkg::LABEL_MAX) begin
                    name_failed_next = 1'b1;
                end
                label_len_next = label_inc;
            end else begin
                name_failed_next = 1'b1;
            end

            // "localhost" match, case folded
            if (char_count_reg < hniv_pkg::LOOPBACK_LEN) begin
                if (lc != hniv_pkg::loopback_char(char_count_reg[3:0])) begin
                    loop_match_next = 1'b0;
                end
            end else begin
                loop_match_next = 1'b0;
            end

            tail_next      = {tail_reg[39:0], lc};
            prev_char_next = host_byte;
            if (char_count_reg != hniv_pkg::CHAR_COUNT_MAX) begin
                char_count_next = char_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg   <= 8'd0;
            octet_value_reg  <= 8'd0;
            octet_digits_reg <= 2'd0;
            dots_seen_reg    <= 2'd0;
            addr_acc_reg     <= 24'd0;
            quad_failed_reg  <= 1'b0;
            label_len_reg    <= 7'd0;
            name_failed_reg  <= 1'b0;
            prev_char_reg    <= 8'd0;
            tail_reg         <= 48'd0;
            loop_match_reg   <= 1'b1;
        end else begin
            char_count_reg   <= char_count_next;
            octet_value_reg  <= octet_value_next;
            octet_digits_reg <= octet_digits_next;
            dots_seen_reg    <= dots_seen_next;
            addr_acc_reg     <= addr_acc_next;
            quad_failed_reg  <= quad_failed_next;
            label_len_reg    <= label_len_next;
            name_failed_reg  <= name_failed_next;
            prev_char_reg    <= prev_char_next;
            tail_reg         <= tail_next;
            loop_match_reg   <= loop_match_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hniv_queue.sv @@
// hniv_queue: short fifo of verdict summaries between scanner and verdict stage
// depends on hniv_pkg
`default_nettype none

module hniv_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire hniv_pkg::verdict_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output hniv_pkg::verdict_t      pop_data
);

    localparam int unsigned PTR_W = $clog2(hniv_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(hniv_pkg::QUEUE_DEPTH + 1);

    hniv_pkg::verdict_t mem_reg [hniv_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(hniv_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hniv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hniv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hniv_back.sv @@
// hniv_back: final verdict (unicast usability, length cap) and output register
// depends on hniv_pkg
`default_nettype none

module hniv_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_not_empty,
    input  wire hniv_pkg::verdict_t q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    host_valid,
    output logic                    parsed_as_ipv4,
    output logic [31:0]             ipv4_address
);

    logic        out_valid_reg, out_valid_next;
    logic        host_valid_reg;
    logic        parsed_reg;
    logic [31:0] addr_reg;
    logic        usable;
    logic        verdict;
    logic [7:0]  first_octet;
    logic [7:0]  last_octet;

    assign first_octet = q_data.addr[31:24];
    assign last_octet  = q_data.addr[7:0];
    assign usable = q_data.addr != 32'd0 && q_data.addr != 32'hFFFF_FFFF &&
                    first_octet != 8'd0 && first_octet != 8'd127 &&
                    first_octet < 8'd224 && last_octet != 8'd0 && last_octet != 8'd255;
    assign verdict = !q_data.too_long && (q_data.quad_ok ? usable : q_data.name_ok);

    // load whenever the output slot is empty or being drained
    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            host_valid_reg <= verdict;
            parsed_reg     <= q_data.quad_ok;
            addr_reg       <= q_data.addr;
        end
    end

    assign out_valid      = out_valid_reg;
    assign host_valid     = host_valid_reg;
    assign parsed_as_ipv4 = parsed_reg;
    assign ipv4_address   = addr_reg;

endmodule

`default_nettype wire

@@ hw/rtl/host_name_or_ipv4_validator.sv @@
// host_name_or_ipv4_validator: top level, scanner + queue + verdict stage
// depends on hniv_pkg, hniv_front, hniv_queue, hniv_back
//
// usage
//   input stream: one beat per host text byte (s_tdata), s_tlast high marks the
//   end-of-text beat, which carries no character and yields exactly one verdict
//   output stream: one beat per text with host_valid, parsed_as_ipv4 and the
//   parsed address (zero unless the text is a well-formed dotted quad)
//   throughput: one input beat per cycle while the queue is not full, set by the byte scanner
//   verdict path: the end-of-text summary is written into the queue, then
//   loaded into the output register that drives m_tvalid
//   stalls: a 2-entry queue sits between scanner and output register, so the
//   scanner keeps taking bytes while a verdict waits on m_tready; s_tready
//   drops only when the queue is full
//   reset: synchronous active-low aresetn empties the queue and output register
//   and returns the scanner to the start of a new text; no clearing pass
//   MAX_HOST_BYTES: longest accepted name, 15 to 253
`default_nettype none

module host_name_or_ipv4_validator #(
    parameter int unsigned MAX_HOST_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] host_byte
    input  wire logic        s_tlast,    // end_of_host
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata     // [0] host_valid, [1] parsed_as_ipv4,
                                         // [33:2] ipv4_address, [39:34] zero
);

    logic               beat_take;
    logic               push;
    hniv_pkg::verdict_t push_data;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    hniv_pkg::verdict_t q_data;
    logic               host_valid;
    logic               parsed_as_ipv4;
    logic [31:0]        ipv4_address;

    // any beat waits only on queue space
    assign s_tready  = !q_full;
    assign beat_take = s_tvalid && s_tready;

    hniv_front #(
        .MAX_HOST_BYTES (MAX_HOST_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_take   (beat_take),
        .host_byte   (s_tdata),
        .end_of_host (s_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    hniv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    hniv_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .host_valid     (host_valid),
        .parsed_as_ipv4 (parsed_as_ipv4),
        .ipv4_address   (ipv4_address)
    );

    assign m_tdata = {6'd0, ipv4_address, parsed_as_ipv4, host_valid};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for host_name_or_ipv4_validator
// streams host texts one byte per beat, predicts each verdict in the bench and
// compares it with the result beats; needs only the rtl of the block
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_HOST_BYTES = 64;
    localparam int unsigned QUAD_TEXT_LIMIT = 16;   // a dotted quad is shorter
    localparam int unsigned RANDOM_BEATS   = 850;
    localparam int SENDER   = 0;
    localparam int RECEIVER = 1;

    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_DASH  = 8'h2D;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [71:0] LOOPBACK_NAME = "localhost";
    localparam logic [47:0] LOCAL_TAIL    = ".local";

    // one input beat: a text byte, or the end marker when last is set
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } host_beat_t;

    // what one end marker should produce
    typedef struct packed {
        int          text_id;
        logic        valid;
        logic        is_quad;
        logic [31:0] addr;
    } host_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;     // [7:0] host_byte
    logic        s_tlast  = 1'b0;      // end_of_host
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;              // [0] host_valid, [1] parsed_as_ipv4,
                                       // [33:2] ipv4_address, [39:34] zero

    host_beat_t    beats_to_send[$];
    host_verdict_t pending_verdicts[$];
    int            beats_queued   = 0;
    int            texts_closed   = 0;
    int            mismatch_count = 0;
    bit            no_idle        = 1'b0;
    int            idle_left[2]   = '{0, 0};
    int            busy_left[2]   = '{0, 0};
    string         name_pool      = "abcdefghijklmnopqrstuvwxyz0123456789";
    string         noise_pool     = ".-09aZz:/";

    // scanner state mirrored in the bench
    logic [7:0]  char_count;
    logic [7:0]  octet_value;
    logic [1:0]  octet_digits;
    logic [1:0]  dots_seen;
    logic [31:0] quad_acc;
    logic        quad_failed;
    logic [6:0]  label_len;
    logic        name_failed;
    logic [7:0]  prev_char;
    logic [47:0] tail_bytes;
    logic        loopback_hit;

    host_name_or_ipv4_validator #(
        .MAX_HOST_BYTES(MAX_HOST_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // character classes and the verdict predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alnum(input logic [7:0] c);
        logic [7:0] f;
        f = lower_ascii(c);
        return is_digit(c) || (f >= "a" && f <= "z");
    endfunction

    // a new text starts from here, also after every verdict
    task automatic clear_scan_state();
        char_count   = '0;
        octet_value  = '0;
        octet_digits = '0;
        dots_seen    = '0;
        quad_acc     = '0;
        quad_failed  = 1'b0;
        label_len    = '0;
        name_failed  = 1'b0;
        prev_char    = '0;
        tail_bytes   = '0;
        loopback_hit = 1'b1;
    endtask

    // dotted quad rule: digits build an octet, a dot closes it
    task automatic scan_quad_char(input logic [7:0] c);
        int unsigned nv;
        if (char_count >= QUAD_TEXT_LIMIT) begin
            quad_failed = 1'b1;
        end
        if (quad_failed) begin
            return;
        end
        if (is_digit(c)) begin
            nv = 32'(octet_value) * 10 + 32'(c) - 32'(CH_ZERO);
            if (octet_digits >= 2'd3 || nv > 255) begin
                quad_failed = 1'b1;
            end else begin
                octet_value  = nv[7:0];
                octet_digits = octet_digits + 2'd1;
            end
        end else if (c == CH_DOT) begin
            if (octet_digits == 2'd0 || dots_seen >= 2'd3) begin
                quad_failed = 1'b1;
            end else begin
                quad_acc     = {quad_acc[23:0], octet_value};
                dots_seen    = dots_seen + 2'd1;
                octet_digits = '0;
                octet_value  = '0;
            end
        end else begin
            quad_failed = 1'b1;
        end
    endtask

    // dns label rule: 1 to 63 of alnum or dash, no dash at either edge
    task automatic scan_name_char(input logic [7:0] c);
        if (c == CH_DOT) begin
            if (label_len == 7'd0 || prev_char == CH_DASH) begin
                name_failed = 1'b1;
            end
            label_len = '0;
        end else if (is_alnum(c) || c == CH_DASH) begin
            if (label_len == 7'd0 && c == CH_DASH) begin
                name_failed = 1'b1;
            end
            if (label_len < 7'd64) begin
                label_len = label_len + 7'd1;
            end
            if (label_len > 7'd63) begin
                name_failed = 1'b1;
            end
        end else begin
            name_failed = 1'b1;
        end
    endtask

    // called once per accepted input beat; an end beat queues a verdict
    task automatic absorb_host_beat(input logic [7:0] c, input logic last);
        logic [7:0]    lc;
        logic [31:0]   addr;
        logic          quad_ok;
        logic          ok;
        host_verdict_t v;
        if (!last) begin
            lc = lower_ascii(c);
            scan_quad_char(c);
            scan_name_char(c);
            if (char_count < 8'd9) begin
                if (lc != LOOPBACK_NAME[8 * (8 - int'(char_count)) +: 8]) begin
                    loopback_hit = 1'b0;
                end
            end else begin
                loopback_hit = 1'b0;
            end
            tail_bytes = {tail_bytes[39:0], lc};
            prev_char  = c;
            if (char_count != 8'd255) begin
                char_count = char_count + 8'd1;
            end
            return;
        end
        addr    = '0;
        quad_ok = !quad_failed && char_count > 0 && char_count < QUAD_TEXT_LIMIT &&
                  dots_seen == 2'd3 && octet_digits != 2'd0;
        if (quad_ok) begin
            // a quad that is not usable unicast gets no second chance as a name
            addr = {quad_acc[23:0], octet_value};
            ok   = addr != 32'h0 && addr != 32'hFFFF_FFFF && addr[31:24] != 8'd0 &&
                   addr[31:24] != 8'd127 && addr[31:24] < 8'd224 &&
                   addr[7:0] != 8'd0 && addr[7:0] != 8'd255;
        end else begin
            ok = !name_failed && char_count > 0 && char_count <= MAX_HOST_BYTES &&
                 label_len != 7'd0 && prev_char != CH_DASH;
            if (char_count >= 8'd6 && tail_bytes == LOCAL_TAIL) begin
                ok = 1'b0;
            end
            if (char_count == 8'd9 && loopback_hit) begin
                ok = 1'b0;
            end
        end
        if (char_count > MAX_HOST_BYTES) begin
            ok = 1'b0;
        end
        v.text_id = texts_closed;
        v.valid   = ok;
        v.is_quad = quad_ok;
        v.addr    = addr;
        pending_verdicts.push_back(v);
        texts_closed++;
        clear_scan_state();
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic push_beat(input logic [7:0] c, input logic last);
        host_beat_t b;
        b.ch   = c;
        b.last = last;
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    // the end beat carries a junk byte that the block must ignore
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_beat(s[i], 1'b0);
        end
        push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] label_char(input bit dash_ok);
        if (dash_ok && $urandom_range(0, 5) == 0) begin
            return CH_DASH;
        end
        return mixed_case(name_pool[$urandom_range(0, 35)]);
    endfunction

    // one random host text; mostly well-formed quads and names, some noise
    task automatic push_random_host();
        logic [7:0] txt[$];
        int         kind;
        int         n;
        int         w;
        int         v;
        int         target;
        string      s;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // dotted quad, octet values biased to the unusable corners
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = 127;
                    2:       v = $urandom_range(223, 255);
                    3:       v = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 999) : 255;
                    default: v = $urandom_range(0, 255);
                endcase
                s = $sformatf("%0d", v);
                w = $urandom_range(1, 3);
                while (s.len() < w) begin
                    s = {"0", s};
                end
                if ($urandom_range(0, 14) == 0) begin
                    s = {"0", s};
                end
                for (int i = 0; i < s.len(); i++) begin
                    txt.push_back(s[i]);
                end
                if (k != n - 1) begin
                    txt.push_back(CH_DOT);
                end
            end
        end else if (kind < 40) begin
            // loopback name and near misses, random case
            case ($urandom_range(0, 3))
                0:       s = "localhost";
                1:       s = "localhos";
                2:       s = "localhostx";
                default: s = "localhost.";
            endcase
            if ($urandom_range(0, 4) == 0) begin
                s = {"a.", s};
            end
            for (int i = 0; i < s.len(); i++) begin
                txt.push_back(mixed_case(s[i]));
            end
        end else if (kind < 76) begin
            // dns name of a few labels
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                w = ($urandom_range(0, 14) == 0) ? $urandom_range(62, 64) : $urandom_range(1, 8);
                for (int j = 0; j < w; j++) begin
                    txt.push_back(label_char((j != 0 && j != w - 1) ||
                                             $urandom_range(0, 9) == 0));
                end
                if (k != n - 1) begin
                    txt.push_back(CH_DOT);
                end
            end
            case ($urandom_range(0, 9))
                0: s = ".local";
                1: s = "local";
                2: s = ".";
                3: s = ".locals";
                default: s = "";
            endcase
            for (int i = 0; i < s.len(); i++) begin
                txt.push_back(mixed_case(s[i]));
            end
        end else if (kind < 80) begin
            // long names around the length limit, rarely past the counter's saturation
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 262)
                                                 : $urandom_range(60, 68);
            while (txt.size() < target) begin
                w = $urandom_range(5, 30);
                for (int j = 0; j < w; j++) begin
                    txt.push_back(label_char(1'b0));
                end
                txt.push_back(CH_DOT);
            end
            while (txt.size() > target) begin
                void'(txt.pop_back());
            end
            if (txt[txt.size() - 1] == CH_DOT) begin
                txt[txt.size() - 1] = "q";
            end
        end else if (kind < 95) begin
            // noise over the whole byte range
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) == 0) begin
                    txt.push_back(noise_pool[$urandom_range(0, noise_pool.len() - 1)]);
                end else begin
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            end
        end else if ($urandom_range(0, 1) == 0) begin
            txt.push_back(8'($urandom_range(0, 255)));
        end
        // an occasional corrupted byte breaks an otherwise good text
        if (txt.size() != 0 && $urandom_range(0, 11) == 0) begin
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        end
        foreach (txt[i]) begin
            push_beat(txt[i], 1'b0);
        end
        push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // idling: bursts of idle cycles between stretches of none
    // ------------------------------------------------------------------

    function automatic bit take_idle(input int side);
        if (no_idle) begin
            return 1'b0;
        end
        if (idle_left[side] > 0) begin
            idle_left[side]--;
            return 1'b1;
        end
        if (busy_left[side] > 0) begin
            busy_left[side]--;
            return 1'b0;
        end
        if ($urandom_range(0, 2) == 0) begin
            idle_left[side] = $urandom_range(0, 15);
            return 1'b1;
        end
        busy_left[side] = $urandom_range(0, 40);
        return 1'b0;
    endfunction

    task automatic wait_until_drained();
        do begin
            @(posedge aclk);
        end while (beats_to_send.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int text_id,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s text %0d: got %h expected %h", what, text_id, got, want);
    endtask

    // ------------------------------------------------------------------
    // input side: beats leave the queue, a held beat stays until accepted
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        host_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_host_beat(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (beats_to_send.size() != 0 && !take_idle(SENDER)) begin
                    nxt = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random backpressure, each verdict beat checked in order
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        host_verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("verdict beat with none pending", -1,
                                    m_tdata[33:2], 32'h0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] != want.valid) begin
                        report_mismatch("host_valid", want.text_id,
                                        32'(m_tdata[0]), 32'(want.valid));
                    end
                    if (m_tdata[1] != want.is_quad) begin
                        report_mismatch("parsed_as_ipv4", want.text_id,
                                        32'(m_tdata[1]), 32'(want.is_quad));
                    end
                    if (m_tdata[33:2] != want.addr) begin
                        report_mismatch("ipv4_address", want.text_id,
                                        m_tdata[33:2], want.addr);
                    end
                end
            end
            m_tready <= !take_idle(RECEIVER);
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed texts, two random phases, drain and verdict
    // ------------------------------------------------------------------

    initial begin
        clear_scan_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty text, unusable loopback quad, loopback name, bad bytes incl. 00 and ff
        push_text("");
        push_text("127.0.0.1");
        push_text("LocalHost");
        push_beat(8'h00, 1'b0);
        push_beat(":", 1'b0);
        push_beat("/", 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);
        wait_until_drained();

        beats_queued = 0;
        while (beats_queued < RANDOM_BEATS / 2) begin
            push_random_host();
        end
        // sender holds off until every verdict of the first half is back
        wait_until_drained();

        while (beats_queued < RANDOM_BEATS) begin
            push_random_host();
        end
        while (beats_to_send.size() > 120) begin
            @(posedge aclk);
        end
        no_idle = 1'b1;
        wait_until_drained();
        // a stray late verdict would still show up within the pipeline depth
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("host_name_or_ipv4_validator test passed");
        end else begin
            $display("host_name_or_ipv4_validator test failed");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2000000;
        $display("host_name_or_ipv4_validator test failed");
        $finish;
    end

endmodule
